// ===== sv/ctdt_pkg.sv =====
// Shared codes, widths and the colour classification for the target table.
`timescale 1ns / 1ps

package ctdt_pkg;

	localparam int COLOR_W     = 3;
	localparam int POINTS_W    = 3;
	localparam int STATUS_W    = 2;
	localparam int THR_W       = 15;
	localparam int ENTRY_IDX_W = 5;
	localparam int FILL_W      = 6;

	localparam logic [THR_W-1:0] THR_RESET = 15'd256;

	localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd0;
	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd1;
	localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd2;
	localparam logic [COLOR_W-1:0] COLOR_ORANGE = 3'd3;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd4;

	localparam logic [POINTS_W-1:0] PTS_RED    = 3'd1;
	localparam logic [POINTS_W-1:0] PTS_GREEN  = 3'd2;
	localparam logic [POINTS_W-1:0] PTS_BLUE   = 3'd3;
	localparam logic [POINTS_W-1:0] PTS_ORANGE = 3'd5;
	localparam logic [POINTS_W-1:0] PTS_YELLOW = 3'd5;
	localparam logic [POINTS_W-1:0] PTS_NONE   = 3'd0;

	localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

	// Classification of one detection, worked out at the front
	typedef struct packed {
		logic                known;
		logic                yellow;
		logic [COLOR_W-1:0]  color;
		logic [POINTS_W-1:0] points;
	} ctdt_class_t;

	function automatic logic [POINTS_W-1:0] points_of(input logic [COLOR_W-1:0] c);
		logic [POINTS_W-1:0] p;
		case (c)
			COLOR_RED:    p = PTS_RED;
			COLOR_GREEN:  p = PTS_GREEN;
			COLOR_BLUE:   p = PTS_BLUE;
			COLOR_ORANGE: p = PTS_ORANGE;
			COLOR_YELLOW: p = PTS_YELLOW;
			default:      p = PTS_NONE;
		endcase
		return p;
	endfunction

endpackage

// ===== sv/ctdt_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module ctdt_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ctdt_front.sv =====
// Front end: takes detections, classifies the colour, holds them in a two-deep queue.
`timescale 1ns / 1ps

module ctdt_front import ctdt_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_pos,
	input  logic signed [COORD_BITS-1:0] y_pos,
	input  logic [COLOR_W-1:0]           color_code,
	output logic                         q_valid,
	input  logic                         q_pop,
	output logic signed [COORD_BITS-1:0] q_x,
	output logic signed [COORD_BITS-1:0] q_y,
	output ctdt_class_t                  q_cls
);

	logic signed [COORD_BITS-1:0] x_q   [2];
	logic signed [COORD_BITS-1:0] y_q   [2];
	ctdt_class_t                  cls_q [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   cnt_q;
	logic                         push;
	logic                         pop;
	ctdt_class_t                  cls_in;

	always_comb begin
		cls_in.known  = color_code inside {[COLOR_RED:COLOR_YELLOW]};
		cls_in.yellow = (color_code == COLOR_YELLOW);
		cls_in.color  = color_code;
		cls_in.points = points_of(color_code);
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			x_q[wr_ptr_q]   <= x_pos;
			y_q[wr_ptr_q]   <= y_pos;
			cls_q[wr_ptr_q] <= cls_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign q_x   = x_q[rd_ptr_q];
	assign q_y   = y_q[rd_ptr_q];
	assign q_cls = cls_q[rd_ptr_q];

endmodule

// ===== sv/ctdt_back.sv =====
// Back end: scans the table for a match, writes the update back, holds the result.
`timescale 1ns / 1ps

module ctdt_back import ctdt_pkg::*; #(
	parameter int CAPACITY   = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [THR_W-1:0]             thr,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic signed [COORD_BITS-1:0] q_x,
	input  logic signed [COORD_BITS-1:0] q_y,
	input  ctdt_class_t                  q_cls,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [STATUS_W-1:0]          status,
	output logic [ENTRY_IDX_W-1:0]       entry_index,
	output logic signed [COORD_BITS-1:0] entry_x,
	output logic signed [COORD_BITS-1:0] entry_y,
	output logic [POINTS_W-1:0]          entry_points,
	output logic [FILL_W-1:0]            fill_count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = COLOR_W + POINTS_W + 2 * COORD_BITS;
	localparam int CMP_W = (COORD_BITS + 1 > THR_W) ? COORD_BITS + 1 : THR_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             scan_q;
	logic                         cmp_vld_q;
	logic [IDX_W-1:0]             cmp_idx_q;
	logic                         found_q;
	logic [IDX_W-1:0]             hit_q;
	logic signed [COORD_BITS-1:0] hit_x_q;
	logic signed [COORD_BITS-1:0] hit_y_q;
	logic [POINTS_W-1:0]          hit_pts_q;
	logic signed [COORD_BITS-1:0] it_x_q;
	logic signed [COORD_BITS-1:0] it_y_q;
	ctdt_class_t                  it_cls_q;

	logic                         res_vld_q;
	logic [STATUS_W-1:0]          status_q;
	logic [ENTRY_IDX_W-1:0]       idx_q;
	logic signed [COORD_BITS-1:0] ex_q;
	logic signed [COORD_BITS-1:0] ey_q;
	logic [POINTS_W-1:0]          pts_q;
	logic [FILL_W-1:0]            fill_q;

	// RAM ports
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ENT_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [ENT_W-1:0]     ram_rdata;

	logic [COLOR_W-1:0]           rd_color;
	logic [POINTS_W-1:0]          rd_pts;
	logic signed [COORD_BITS-1:0] rd_x;
	logic signed [COORD_BITS-1:0] rd_y;
	logic signed [COORD_BITS:0]   dx;
	logic signed [COORD_BITS:0]   dy;
	logic [COORD_BITS:0]          ax;
	logic [COORD_BITS:0]          ay;
	logic                         match;
	logic                         issue;
	logic                         out_free;

	logic signed [COORD_BITS:0]   sum_x;
	logic signed [COORD_BITS:0]   sum_y;
	logic signed [COORD_BITS-1:0] upd_x;
	logic signed [COORD_BITS-1:0] upd_y;
	logic [STATUS_W-1:0]          res_status;
	logic [IDX_W-1:0]             res_idx;
	logic signed [COORD_BITS-1:0] res_x;
	logic signed [COORD_BITS-1:0] res_y;
	logic [POINTS_W-1:0]          res_pts;
	logic [CNT_W-1:0]             res_cnt;
	logic                         res_wr;
	logic                         load;

	ctdt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_color = ram_rdata[ENT_W-1 -: COLOR_W];
	assign rd_pts   = ram_rdata[ENT_W-COLOR_W-1 -: POINTS_W];
	assign rd_x     = ram_rdata[2*COORD_BITS-1:COORD_BITS];
	assign rd_y     = ram_rdata[COORD_BITS-1:0];

	// Per-axis distance at full precision
	always_comb begin
		dx    = $signed({it_x_q[COORD_BITS-1], it_x_q}) - $signed({rd_x[COORD_BITS-1], rd_x});
		dy    = $signed({it_y_q[COORD_BITS-1], it_y_q}) - $signed({rd_y[COORD_BITS-1], rd_y});
		ax    = dx[COORD_BITS] ? unsigned'(-dx) : unsigned'(dx);
		ay    = dy[COORD_BITS] ? unsigned'(-dy) : unsigned'(dy);
		match = cmp_vld_q && (rd_color == it_cls_q.color)
			&& (CMP_W'(ax) < CMP_W'(thr)) && (CMP_W'(ay) < CMP_W'(thr));
	end

	assign issue    = (state_q == S_SCAN) && (scan_q < cnt_q);
	assign ram_re   = issue;
	assign out_free = !res_vld_q || !out_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign load     = (state_q == S_DONE) && out_free;

	// Floored average (yellow takes the new position): arithmetic shift of the widened sum
	always_comb begin
		sum_x = $signed({hit_x_q[COORD_BITS-1], hit_x_q}) + $signed({it_x_q[COORD_BITS-1], it_x_q});
		sum_y = $signed({hit_y_q[COORD_BITS-1], hit_y_q}) + $signed({it_y_q[COORD_BITS-1], it_y_q});
		upd_x = it_cls_q.yellow ? it_x_q : sum_x[COORD_BITS:1];
		upd_y = it_cls_q.yellow ? it_y_q : sum_y[COORD_BITS:1];
	end

	always_comb begin
		res_status = ST_IGNORED;
		res_idx    = '0;
		res_x      = '0;
		res_y      = '0;
		res_pts    = '0;
		res_cnt    = cnt_q;
		res_wr     = 1'b0;
		if (!it_cls_q.known) begin
			res_status = ST_IGNORED;
		end else if (found_q) begin
			res_status = ST_UPDATED;
			res_idx    = hit_q;
			res_x      = upd_x;
			res_y      = upd_y;
			res_pts    = hit_pts_q;
			res_wr     = 1'b1;
		end else if (cnt_q == CAP_CNT) begin
			res_status = ST_FULL;
		end else begin
			res_status = ST_INSERTED;
			res_idx    = cnt_q[IDX_W-1:0];
			res_x      = it_x_q;
			res_y      = it_y_q;
			res_pts    = it_cls_q.points;
			res_cnt    = cnt_q + CNT_W'(1);
			res_wr     = 1'b1;
		end
	end

	assign ram_we    = load && res_wr;
	assign ram_waddr = res_idx;
	assign ram_wdata = {it_cls_q.color, res_pts, res_x, res_y};

	// Item and hit registers carry no reset
	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_x_q   <= q_x;
			it_y_q   <= q_y;
			it_cls_q <= q_cls;
		end
		cmp_idx_q <= scan_q[IDX_W-1:0];
		if (match) begin
			hit_q     <= cmp_idx_q;
			hit_x_q   <= rd_x;
			hit_y_q   <= rd_y;
			hit_pts_q <= rd_pts;
		end
		if (load) begin
			status_q <= res_status;
			idx_q    <= ENTRY_IDX_W'(res_idx);
			ex_q     <= res_x;
			ey_q     <= res_y;
			pts_q    <= res_pts;
			fill_q   <= FILL_W'(res_cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						scan_q    <= '0;
						cmp_vld_q <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= q_cls.known ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					cmp_vld_q <= issue;
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (match) begin
						found_q <= 1'b1;
					end
					if (!issue && !cmp_vld_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						cnt_q   <= res_cnt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load) begin
				res_vld_q <= 1'b1;
			end else if (!out_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid    = res_vld_q;
	assign status       = status_q;
	assign entry_index  = idx_q;
	assign entry_x      = ex_q;
	assign entry_y      = ey_q;
	assign entry_points = pts_q;
	assign fill_count   = fill_q;

endmodule

// ===== sv/colored_target_dedup_table.sv =====
// Top level of the coloured target de-duplication table.
// Each detection is popped from the queue head, scanned against the live entries (skipped if ignored), then registered.
// The back end takes a new detection only after the last result is loaded; its scan reads one entry a cycle.
// Front queue holds two detections, so input transfers continue while the back end scans.
// Reset (arst_n low, asynchronous): fill count and queues empty, threshold back to 256.
// The table memory itself is not cleared; only entries below the fill count are ever read.
`timescale 1ns / 1ps

module colored_target_dedup_table import ctdt_pkg::*; #(
	parameter int CAPACITY   = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [THR_W-1:0]             cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_pos,
	input  logic signed [COORD_BITS-1:0] y_pos,
	input  logic [COLOR_W-1:0]           color_code,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [STATUS_W-1:0]          status,
	output logic [ENTRY_IDX_W-1:0]       entry_index,
	output logic signed [COORD_BITS-1:0] entry_x,
	output logic signed [COORD_BITS-1:0] entry_y,
	output logic [POINTS_W-1:0]          entry_points,
	output logic [FILL_W-1:0]            fill_count
);

	// separation threshold, per axis, strict less-than
	logic [THR_W-1:0] thr_q;

	// queue head towards the back end
	logic                         q_valid;
	logic                         q_pop;
	logic signed [COORD_BITS-1:0] q_x;
	logic signed [COORD_BITS-1:0] q_y;
	ctdt_class_t                  q_cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// front: input transfer, colour classification, two-deep queue
	ctdt_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.color_code (color_code),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_x        (q_x),
		.q_y        (q_y),
		.q_cls      (q_cls)
	);

	// back: table scan (highest matching index wins), write-back, result register
	ctdt_back #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.thr          (thr_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_x          (q_x),
		.q_y          (q_y),
		.q_cls        (q_cls),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_index  (entry_index),
		.entry_x      (entry_x),
		.entry_y      (entry_y),
		.entry_points (entry_points),
		.fill_count   (fill_count)
	);

endmodule

// ===== tb/colored_target_dedup_table_test.sv =====
// Self-checking testbench for the coloured target de-duplication table.
`timescale 1ns / 1ps

module colored_target_dedup_table_test;
	import ctdt_pkg::*;

	localparam int TABLE_DEPTH  = 32;
	localparam int COORD_W      = 16;
	localparam int BATCH_LEN    = 40;
	localparam int SETTLE       = 50;      // beyond the worst scan of a full table
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 210;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int KNOWN_COLORS = COLOR_YELLOW + 1;
	localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COLOR_W-1:0]        color;
	} detection_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [ENTRY_IDX_W-1:0]    idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [POINTS_W-1:0]       points;
		logic [FILL_W-1:0]         fill;
	} table_result_t;

	// Block ports; every input starts at a known value
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [THR_W-1:0]          cfg_wr_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [COORD_W-1:0] x_pos = '0;
	logic signed [COORD_W-1:0] y_pos = '0;
	logic [COLOR_W-1:0]        color_code = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [STATUS_W-1:0]       status;
	logic [ENTRY_IDX_W-1:0]    entry_index;
	logic signed [COORD_W-1:0] entry_x;
	logic signed [COORD_W-1:0] entry_y;
	logic [POINTS_W-1:0]       entry_points;
	logic [FILL_W-1:0]         fill_count;

	// Shadow of the table: contents, fill count and the match threshold
	logic [COLOR_W-1:0]        tbl_color [TABLE_DEPTH];
	logic signed [COORD_W-1:0] tbl_x [TABLE_DEPTH];
	logic signed [COORD_W-1:0] tbl_y [TABLE_DEPTH];
	logic [POINTS_W-1:0]       tbl_points [TABLE_DEPTH];
	int                        tbl_fill = 0;
	logic [THR_W-1:0]          sep_thr = THR_RESET;

	detection_t    pending_detections [$];
	table_result_t results_due [$];

	int  sent_count = 0;
	int  taken_count = 0;
	int  checked_count = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  idle_pct = 0;         // chance per cycle of starting an idle burst, both sides
	int  send_gap = 0;
	int  rcv_gap = 0;
	logic hold_req = 1'b0;

	colored_target_dedup_table #(
		.CAPACITY   (TABLE_DEPTH),
		.COORD_BITS (COORD_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.color_code   (color_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_index  (entry_index),
		.entry_x      (entry_x),
		.entry_y      (entry_y),
		.entry_points (entry_points),
		.fill_count   (fill_count)
	);

	always #5 clk = ~clk;

	// Watchdog: a lost or stuck transfer ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL colored_target_dedup_table");
			$finish;
		end
	end

	task automatic flag_mismatch(input string field, input int got, input int want);
		$display("result %0d: %s is %0d, expected %0d", checked_count, field, got, want);
		mismatch_count++;
	endtask

	// Table update for one accepted detection; queues the result it must produce.
	// Last matching slot wins, differences are taken at full precision.
	task automatic track_detection(input logic signed [COORD_W-1:0] nx,
			input logic signed [COORD_W-1:0] ny, input logic [COLOR_W-1:0] c);
		table_result_t r;
		int hit;
		int dx;
		int dy;
		r = '0;
		hit = -1;
		if (c > COLOR_YELLOW) begin
			r.status = ST_IGNORED;
		end else begin
			for (int i = 0; i < tbl_fill; i++) begin
				dx = int'(nx) - int'(tbl_x[i]);
				dy = int'(ny) - int'(tbl_y[i]);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				if (tbl_color[i] == c && dx < int'(sep_thr) && dy < int'(sep_thr))
					hit = i;
			end
			if (hit >= 0) begin
				// yellow jumps to the new sighting, the rest take the floored mean
				if (c == COLOR_YELLOW) begin
					tbl_x[hit] = nx;
					tbl_y[hit] = ny;
				end else begin
					tbl_x[hit] = COORD_W'((int'(tbl_x[hit]) + int'(nx)) >>> 1);
					tbl_y[hit] = COORD_W'((int'(tbl_y[hit]) + int'(ny)) >>> 1);
				end
				r.status = ST_UPDATED;
			end else if (tbl_fill >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				hit = tbl_fill;
				tbl_color[hit] = c;
				tbl_x[hit] = nx;
				tbl_y[hit] = ny;
				case (c)
					COLOR_RED:    tbl_points[hit] = PTS_RED;
					COLOR_GREEN:  tbl_points[hit] = PTS_GREEN;
					COLOR_BLUE:   tbl_points[hit] = PTS_BLUE;
					COLOR_ORANGE: tbl_points[hit] = PTS_ORANGE;
					default:      tbl_points[hit] = PTS_YELLOW;
				endcase
				tbl_fill++;
				r.status = ST_INSERTED;
			end
			if (hit >= 0) begin
				r.idx = ENTRY_IDX_W'(hit);
				r.x = tbl_x[hit];
				r.y = tbl_y[hit];
				r.points = tbl_points[hit];
			end
		end
		r.fill = FILL_W'(tbl_fill);
		results_due = {results_due, r};
	endtask

	// Sender: one detection per transfer, held steady while stalled
	always @(posedge clk) begin
		detection_t nxt;
		if (in_valid && !in_stall) begin
			track_detection(x_pos, y_pos, color_code);
			taken_count++;
		end
		if (!(in_valid && in_stall)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_detections.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
				send_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (pending_detections.size() != 0) begin
				nxt = pending_detections.pop_front();
				in_valid   <= 1'b1;
				x_pos      <= nxt.x;
				y_pos      <= nxt.y;
				color_code <= nxt.color;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result transfer against the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		if (out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				flag_mismatch("queued expectations", 0, 1);
			end else begin
				want = results_due.pop_front();
				if (status != want.status)
					flag_mismatch("status", status, want.status);
				if (entry_index != want.idx)
					flag_mismatch("entry_index", entry_index, want.idx);
				if (entry_x != want.x)
					flag_mismatch("entry_x", entry_x, want.x);
				if (entry_y != want.y)
					flag_mismatch("entry_y", entry_y, want.y);
				if (entry_points != want.points)
					flag_mismatch("entry_points", entry_points, want.points);
				if (fill_count != want.fill)
					flag_mismatch("fill_count", fill_count, want.fill);
				checked_count++;
			end
		end
		if (rcv_gap > 0)
			rcv_gap--;
		else if ($urandom_range(0, 99) < idle_pct)
			rcv_gap = $urandom_range(1, 9);
		out_stall <= hold_req || rcv_gap > 0;
	end

	// Long receiver hold-off part way in, so the input side backs up and stalls
	initial begin
		while (taken_count < HOLD_AT) @(posedge clk);
		hold_req <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_req <= 1'b0;
	end

	task automatic queue_detection(input int x, input int y, input logic [COLOR_W-1:0] c);
		detection_t d;
		d.x = COORD_W'(x);
		d.y = COORD_W'(y);
		d.color = c;
		pending_detections = {pending_detections, d};
		sent_count++;
	endtask

	// Idle once every queued detection has produced its checked result
	task automatic wait_drained();
		while (checked_count != sent_count) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] thr);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= thr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sep_thr = thr;
	endtask

	function automatic int clamp_coord(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Random detections, mostly aimed at live entries so that updates and
	// threshold edges get exercised once the table has filled.
	task automatic random_phase(input logic [THR_W-1:0] thr, input int count, input bit calm);
		int roll;
		int s;
		int span;
		int ox;
		int oy;
		logic [COLOR_W-1:0] c;
		write_threshold(thr);
		for (int n = 0; n < count; n += BATCH_LEN) begin
			idle_pct = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 25));
			for (int k = 0; k < BATCH_LEN && n + k < count; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70 && tbl_fill > 0) begin
					s = $urandom_range(0, tbl_fill - 1);
					span = int'(sep_thr) / 2;
					if ($urandom_range(0, 9) == 0) begin
						// right on the threshold or one inside it
						ox = int'(sep_thr) - int'($urandom_range(0, 1));
						oy = int'($urandom_range(0, span));
						if ($urandom_range(0, 1)) ox = -ox;
					end else begin
						ox = int'($urandom_range(0, 2 * span)) - span;
						oy = int'($urandom_range(0, 2 * span)) - span;
					end
					if ($urandom_range(0, 1)) begin
						s = ox;
						ox = oy;
						oy = s;
						s = $urandom_range(0, tbl_fill - 1);
					end
					c = tbl_color[s];
					if (roll >= 60)
						c = COLOR_W'((int'(c) + 1 + int'($urandom_range(0, 3))) % KNOWN_COLORS);
					queue_detection(clamp_coord(int'(tbl_x[s]) + ox),
						clamp_coord(int'(tbl_y[s]) + oy), c);
				end else if (roll < 82) begin
					queue_detection(int'($signed(COORD_W'($urandom))),
						int'($signed(COORD_W'($urandom))),
						COLOR_W'($urandom_range(COLOR_YELLOW + 1, COLOR_MAX)));
				end else begin
					queue_detection(int'($signed(COORD_W'($urandom))),
						int'($signed(COORD_W'($urandom))),
						COLOR_W'($urandom_range(COLOR_RED, COLOR_YELLOW)));
				end
			end
			wait_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: exact-match threshold first so two blue entries can sit close
		idle_pct = 15;
		write_threshold(15'd1);
		queue_detection(0, 0, COLOR_BLUE);
		queue_detection(10, 0, COLOR_BLUE);
		queue_detection(0, 0, COLOR_BLUE);             // exact hit, mean of equals
		write_threshold(THR_RESET);
		queue_detection(5, 0, COLOR_BLUE);             // both blues match, later slot wins
		queue_detection(-32768, -32768, COLOR_RED);
		queue_detection(-32513, -32513, COLOR_RED);    // just inside, negative floor
		queue_detection(-32768, -32512, COLOR_RED);    // inside the averaged entry, so it updates
		queue_detection(32767, 32767, COLOR_GREEN);
		queue_detection(32511, 32767, COLOR_GREEN);    // x exactly on the threshold
		queue_detection(32767, 32766, COLOR_GREEN);
		queue_detection(32767, 32767, COLOR_RED);      // same spot, other colour
		queue_detection(-1, -1, COLOR_ORANGE);
		queue_detection(0, 0, COLOR_ORANGE);           // mean -1/2 floors to -1
		queue_detection(1000, -1000, COLOR_YELLOW);
		queue_detection(1100, -1050, COLOR_YELLOW);    // yellow takes the new position
		queue_detection(-32768, 32767, COLOR_YELLOW + 1);
		queue_detection(32767, -32768, COLOR_YELLOW + 2);
		queue_detection(0, 0, COLOR_MAX);
		queue_detection(-32768, 32767, COLOR_GREEN);
		wait_drained();

		// Random phases over several thresholds; the table fills in the first
		random_phase(THR_RESET, 480, 1'b0);
		random_phase('1, 240, 1'b0);
		random_phase('0, 120, 1'b0);
		random_phase(15'd1, 160, 1'b0);
		random_phase(THR_W'($urandom_range(2, 2000)), 320, 1'b0);
		random_phase(15'd100, 520, 1'b1);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (results_due.size() != 0) begin
			flag_mismatch("results outstanding", results_due.size(), 0);
		end
		if (mismatch_count == 0) begin
			$display("PASS colored_target_dedup_table");
		end else begin
			$display("FAIL colored_target_dedup_table");
		end
		$finish;
	end

endmodule
